[sv/ttd_pkg.sv]
// Shared types, codes and edge tables for the tetrahedron tear detector.
package ttd_pkg;

   // Request mode codes
   localparam logic [1:0] MODE_DETECT    = 2'd0;
   localparam logic [1:0] MODE_CLEAR_ONE = 2'd1;
   localparam logic [1:0] MODE_CLEAR_ALL = 2'd2;
   localparam logic [1:0] MODE_IGNORED   = 2'd3;

   // Fixed field widths
   localparam int ID_W    = 12;
   localparam int POS_W   = 48;
   localparam int LEN_W   = 34;   // squared length
   localparam int QUO_W   = 58;   // squared ratio, Q.24 scaled
   localparam int ROOT_W  = 29;   // stretch before saturation
   localparam int SREM_W  = 31;   // square root remainder
   localparam int FRAC_SH = 24;

   localparam logic [ROOT_W-1:0] STRETCH_ONE = ROOT_W'(4096);
   localparam logic [15:0]       THR_RESET   = 16'd6144;
   localparam logic [2:0]        LAST_EDGE   = 3'd5;

   // One-hot sequencer states
   typedef enum logic [8:0] {
      ST_CLEAR  = 9'b000000001,
      ST_IDLE   = 9'b000000010,
      ST_LOOKUP = 9'b000000100,
      ST_SQ     = 9'b000001000,
      ST_PREP   = 9'b000010000,
      ST_DIV    = 9'b000100000,
      ST_SQRT   = 9'b001000000,
      ST_CMP    = 9'b010000000,
      ST_FINISH = 9'b100000000
   } state_type;

   // First corner of an edge, order 01,02,03,12,13,23
   function automatic logic [1:0] edge_p(input logic [2:0] e);
      logic [1:0] r;
      unique case (e)
         3'd0, 3'd1, 3'd2: r = 2'd0;
         3'd3, 3'd4:       r = 2'd1;
         3'd5:             r = 2'd2;
         default:          r = 2'd0;
      endcase
      return r;
   endfunction

   // Second corner of an edge
   function automatic logic [1:0] edge_q(input logic [2:0] e);
      logic [1:0] r;
      unique case (e)
         3'd0:       r = 2'd1;
         3'd1, 3'd3: r = 2'd2;
         3'd2, 3'd4, 3'd5: r = 2'd3;
         default:    r = 2'd1;
      endcase
      return r;
   endfunction

endpackage

[sv/tetrahedron_tear_detector.sv]
// Tetrahedron tear detector: flag memory, edge measurement and serial divide/root.
// Detect reads the torn flag; if clear, each edge is squared, set up, divided by the
// one-bit-a-cycle divider, rooted (divide and root skipped for a zero rest length) and
// compared, then the result is written. Clear-one and ignored requests go straight to
// the result; clear-all first sweeps the flag memory. One request at a time; a result
// may wait in the output register while the next request is accepted. After reset the
// flag memory is swept clear before the first request is accepted.
module tetrahedron_tear_detector #(
   parameter int TETRAHEDRA = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [11:0] req_tet_number,
   input  logic [47:0] req_corner_ids,
   input  logic [15:0] req_resistance,
   input  logic [47:0] req_cur_corner0,
   input  logic [47:0] req_cur_corner1,
   input  logic [47:0] req_cur_corner2,
   input  logic [47:0] req_cur_corner3,
   input  logic [47:0] req_rest_corner0,
   input  logic [47:0] req_rest_corner1,
   input  logic [47:0] req_rest_corner2,
   input  logic [47:0] req_rest_corner3,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_tear_found,
   output logic        rsp_already_torn,
   output logic [11:0] rsp_torn_tet,
   output logic [2:0]  rsp_edge_number,
   output logic [11:0] rsp_vertex_a,
   output logic [11:0] rsp_vertex_b,
   output logic [15:0] rsp_peak_stretch,
   output logic [47:0] rsp_tear_midpoint,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_tear_threshold
);

   localparam int IW = (TETRAHEDRA > 1) ? $clog2(TETRAHEDRA) : 1;
   localparam int LW = ttd_pkg::LEN_W;
   localparam int QW = ttd_pkg::QUO_W;
   localparam int RW = ttd_pkg::ROOT_W;
   localparam int SW = ttd_pkg::SREM_W;

   // Torn flag memory
   logic          flag_mem [TETRAHEDRA];
   logic          rd_ff;
   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   logic          mem_wdata;
   logic          mem_re;
   logic [IW-1:0] mem_raddr;

   ttd_pkg::state_type state_ff, state_in;
   logic [1:0]    mode_ff, mode_in;
   logic [11:0]   tet_ff, tet_in;
   logic [47:0]   ids_ff, ids_in;
   logic [47:0]   cur_ff [4];
   logic [47:0]   cur_in [4];
   logic [47:0]   rest_ff [4];
   logic [47:0]   rest_in [4];
   logic [31:0]   thr_prod_ff, thr_prod_in;
   logic          in_range_ff, in_range_in;
   logic [IW-1:0] addr_ff, addr_in;
   logic          torn_ff, torn_in;
   logic          detect_ff, detect_in;
   logic [2:0]    edge_ff, edge_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [LW-1:0] lc_ff, lc_in;
   logic [LW-1:0] lr_ff, lr_in;
   logic [31:0]   prod_ff, prod_in;
   logic [LW-1:0] rem_ff, rem_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [SW-1:0] srem_ff, srem_in;
   logic [RW-1:0] root_ff, root_in;
   logic [RW-1:0] best_ff, best_in;
   logic [2:0]    best_edge_ff, best_edge_in;
   logic          best_valid_ff, best_valid_in;
   logic [IW-1:0] clr_addr_ff, clr_addr_in;
   logic          clr_item_ff, clr_item_in;
   logic [15:0]   thr_ff, thr_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          tear_found_ff, tear_found_in;
   logic          already_torn_ff, already_torn_in;
   logic [11:0]   torn_tet_ff, torn_tet_in;
   logic [2:0]    edge_number_ff, edge_number_in;
   logic [11:0]   vertex_a_ff, vertex_a_in;
   logic [11:0]   vertex_b_ff, vertex_b_in;
   logic [15:0]   peak_ff, peak_in;
   logic [47:0]   mid_ff, mid_in;

   logic          req_take;
   logic          rsp_free;
   logic [31:0]   tet_ext;
   logic [IW-1:0] req_addr;
   logic          req_in_range;

   // Edge measurement operands
   logic [1:0]         sq_p, sq_q;
   logic [1:0]         sq_axis;
   logic               sq_cur;
   logic [47:0]        sq_a, sq_b;
   logic signed [16:0] sq_d;
   logic signed [33:0] sq_sq;

   // Divider and root step
   logic [LW:0]    div_trial;
   logic           div_ge;
   logic [LW:0]    div_diff;
   logic [SW+1:0]  sqrt_trial;
   logic [SW+1:0]  sqrt_sub;
   logic           sqrt_ge;
   logic [SW+1:0]  sqrt_diff;

   // Result assembly
   logic [1:0]  res_p, res_q;
   logic [47:0] res_a, res_b;
   logic [47:0] res_mid;
   logic        res_gt;
   logic        res_tear;
   logic        res_edge_ok;

   // Floor of the mean of two signed Q7.8 coordinates
   function automatic logic [15:0] mid_axis(input logic [15:0] a, input logic [15:0] b);
      logic signed [16:0] s;
      begin
         s = 17'($signed(a)) + 17'($signed(b));
         return s[16:1];
      end
   endfunction

   assign req_take     = req_valid && !req_stall;
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign req_stall    = (state_ff != ttd_pkg::ST_IDLE);
   assign csr_ready    = 1'b1;
   assign tet_ext      = {20'b0, req_tet_number};
   assign req_addr     = tet_ext[IW-1:0];
   assign req_in_range = tet_ext < 32'(TETRAHEDRA);

   // Pick the coordinate pair for the current square step
   always_comb begin
      sq_p = ttd_pkg::edge_p(edge_ff);
      sq_q = ttd_pkg::edge_q(edge_ff);
      sq_cur = cnt_ff < 6'd3;
      unique case (cnt_ff)
         6'd0, 6'd3: sq_axis = 2'd0;
         6'd1, 6'd4: sq_axis = 2'd1;
         6'd2, 6'd5: sq_axis = 2'd2;
         default:    sq_axis = 2'd0;
      endcase
      sq_a  = sq_cur ? cur_ff[sq_p] : rest_ff[sq_p];
      sq_b  = sq_cur ? cur_ff[sq_q] : rest_ff[sq_q];
      sq_d  = 17'($signed(sq_b[16*sq_axis +: 16])) - 17'($signed(sq_a[16*sq_axis +: 16]));
      sq_sq = sq_d * sq_d;
   end

   // Restoring divide and square root steps
   always_comb begin
      div_trial  = {rem_ff, quo_ff[QW-1]};
      div_ge     = div_trial >= {1'b0, lr_ff};
      div_diff   = div_trial - {1'b0, lr_ff};
      sqrt_trial = {srem_ff, quo_ff[QW-1 -: 2]};
      sqrt_sub   = {{(SW+2-RW-2){1'b0}}, root_ff, 2'b01};
      sqrt_ge    = sqrt_trial >= sqrt_sub;
      sqrt_diff  = sqrt_trial - sqrt_sub;
   end

   // Result fields from the chosen edge
   always_comb begin
      res_p = ttd_pkg::edge_p(best_edge_ff);
      res_q = ttd_pkg::edge_q(best_edge_ff);
      res_a = cur_ff[res_p];
      res_b = cur_ff[res_q];
      res_mid = {mid_axis(res_a[47:32], res_b[47:32]),
                 mid_axis(res_a[31:16], res_b[31:16]),
                 mid_axis(res_a[15:0],  res_b[15:0])};
      res_gt      = {best_ff, 12'b0} > {{(RW+12-32){1'b0}}, thr_prod_ff};
      res_edge_ok = detect_ff && best_valid_ff;
      res_tear    = res_edge_ok && res_gt;
   end

   // Sequencer
   always_comb begin
      state_in        = state_ff;
      mode_in         = mode_ff;
      tet_in          = tet_ff;
      ids_in          = ids_ff;
      cur_in          = cur_ff;
      rest_in         = rest_ff;
      thr_prod_in     = thr_prod_ff;
      in_range_in     = in_range_ff;
      addr_in         = addr_ff;
      torn_in         = torn_ff;
      detect_in       = detect_ff;
      edge_in         = edge_ff;
      cnt_in          = cnt_ff;
      lc_in           = lc_ff;
      lr_in           = lr_ff;
      prod_in         = prod_ff;
      rem_in          = rem_ff;
      quo_in          = quo_ff;
      srem_in         = srem_ff;
      root_in         = root_ff;
      best_in         = best_ff;
      best_edge_in    = best_edge_ff;
      best_valid_in   = best_valid_ff;
      clr_addr_in     = clr_addr_ff;
      clr_item_in     = clr_item_ff;
      thr_in          = thr_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      tear_found_in   = tear_found_ff;
      already_torn_in = already_torn_ff;
      torn_tet_in     = torn_tet_ff;
      edge_number_in  = edge_number_ff;
      vertex_a_in     = vertex_a_ff;
      vertex_b_in     = vertex_b_ff;
      peak_in         = peak_ff;
      mid_in          = mid_ff;
      mem_we          = 1'b0;
      mem_waddr       = addr_ff;
      mem_wdata       = 1'b0;
      mem_re          = 1'b0;
      mem_raddr       = req_addr;

      // take a threshold write
      if (csr_valid && csr_ready) begin
         thr_in = csr_tear_threshold;
      end

      unique case (state_ff)
         ttd_pkg::ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == IW'(TETRAHEDRA - 1)) begin
               clr_addr_in = '0;
               clr_item_in = 1'b0;
               state_in    = clr_item_ff ? ttd_pkg::ST_FINISH : ttd_pkg::ST_IDLE;
            end
         end
         ttd_pkg::ST_IDLE: begin
            if (req_take) begin
               mode_in     = req_mode;
               tet_in      = req_tet_number;
               ids_in      = req_corner_ids;
               cur_in[0]   = req_cur_corner0;
               cur_in[1]   = req_cur_corner1;
               cur_in[2]   = req_cur_corner2;
               cur_in[3]   = req_cur_corner3;
               rest_in[0]  = req_rest_corner0;
               rest_in[1]  = req_rest_corner1;
               rest_in[2]  = req_rest_corner2;
               rest_in[3]  = req_rest_corner3;
               thr_prod_in = thr_ff * req_resistance;
               in_range_in = req_in_range;
               addr_in     = req_addr;
               torn_in     = 1'b0;
               detect_in   = 1'b0;
               mem_re      = 1'b1;
               if (req_mode == ttd_pkg::MODE_CLEAR_ALL) begin
                  clr_item_in = 1'b1;
                  clr_addr_in = '0;
                  state_in    = ttd_pkg::ST_CLEAR;
               end else if (req_mode == ttd_pkg::MODE_DETECT && req_in_range) begin
                  state_in = ttd_pkg::ST_LOOKUP;
               end else begin
                  state_in = ttd_pkg::ST_FINISH;
               end
            end
         end
         ttd_pkg::ST_LOOKUP: begin
            if (rd_ff) begin
               torn_in  = 1'b1;
               state_in = ttd_pkg::ST_FINISH;
            end else begin
               detect_in     = 1'b1;
               edge_in       = '0;
               cnt_in        = '0;
               best_in       = '0;
               best_edge_in  = '0;
               best_valid_in = 1'b0;
               state_in      = ttd_pkg::ST_SQ;
            end
         end
         ttd_pkg::ST_SQ: begin
            // square one difference, accumulate the previous one
            prod_in = sq_sq[31:0];
            if (cnt_ff == 6'd0) begin
               lc_in = '0;
               lr_in = '0;
            end else if (cnt_ff <= 6'd3) begin
               lc_in = lc_ff + LW'(prod_ff);
            end else begin
               lr_in = lr_ff + LW'(prod_ff);
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd6) begin
               state_in = ttd_pkg::ST_PREP;
            end
         end
         ttd_pkg::ST_PREP: begin
            if (lr_ff == '0) begin
               root_in  = ttd_pkg::STRETCH_ONE;
               state_in = ttd_pkg::ST_CMP;
            end else begin
               rem_in   = '0;
               quo_in   = {lc_ff, {ttd_pkg::FRAC_SH{1'b0}}};
               cnt_in   = 6'(QW - 1);
               state_in = ttd_pkg::ST_DIV;
            end
         end
         ttd_pkg::ST_DIV: begin
            rem_in = div_ge ? div_diff[LW-1:0] : div_trial[LW-1:0];
            quo_in = {quo_ff[QW-2:0], div_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               srem_in  = '0;
               root_in  = '0;
               cnt_in   = 6'(RW - 1);
               state_in = ttd_pkg::ST_SQRT;
            end
         end
         ttd_pkg::ST_SQRT: begin
            srem_in = sqrt_ge ? sqrt_diff[SW-1:0] : sqrt_trial[SW-1:0];
            root_in = {root_ff[RW-2:0], sqrt_ge};
            quo_in  = {quo_ff[QW-3:0], 2'b00};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ttd_pkg::ST_CMP;
            end
         end
         ttd_pkg::ST_CMP: begin
            // keep the first strict maximum
            if (root_ff > best_ff) begin
               best_in       = root_ff;
               best_edge_in  = edge_ff;
               best_valid_in = 1'b1;
            end
            if (edge_ff == ttd_pkg::LAST_EDGE) begin
               state_in = ttd_pkg::ST_FINISH;
            end else begin
               edge_in  = edge_ff + 1'b1;
               cnt_in   = '0;
               state_in = ttd_pkg::ST_SQ;
            end
         end
         ttd_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               tear_found_in   = res_tear;
               already_torn_in = torn_ff;
               torn_tet_in     = tet_ff;
               edge_number_in  = res_edge_ok ? best_edge_ff : 3'd0;
               vertex_a_in     = res_edge_ok ? ids_ff[12*res_p +: 12] : 12'd0;
               vertex_b_in     = res_edge_ok ? ids_ff[12*res_q +: 12] : 12'd0;
               peak_in         = !res_edge_ok ? 16'd0 :
                                 (best_ff > RW'(16'hFFFF)) ? 16'hFFFF : best_ff[15:0];
               mid_in          = res_edge_ok ? res_mid : 48'd0;
               // update the flag of this tetrahedron
               if (res_tear) begin
                  mem_we    = 1'b1;
                  mem_wdata = 1'b1;
               end else if (mode_ff == ttd_pkg::MODE_CLEAR_ONE && in_range_ff) begin
                  mem_we    = 1'b1;
                  mem_wdata = 1'b0;
               end
               state_in = ttd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ttd_pkg::ST_IDLE;
         end
      endcase
   end

   // Flag memory port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         flag_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= flag_mem[mem_raddr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ttd_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         clr_item_ff  <= 1'b0;
         thr_ff       <= ttd_pkg::THR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_item_ff  <= clr_item_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and datapath registers
   always_ff @(posedge clock) begin
      mode_ff         <= mode_in;
      tet_ff          <= tet_in;
      ids_ff          <= ids_in;
      cur_ff          <= cur_in;
      rest_ff         <= rest_in;
      thr_prod_ff     <= thr_prod_in;
      in_range_ff     <= in_range_in;
      addr_ff         <= addr_in;
      torn_ff         <= torn_in;
      detect_ff       <= detect_in;
      edge_ff         <= edge_in;
      cnt_ff          <= cnt_in;
      lc_ff           <= lc_in;
      lr_ff           <= lr_in;
      prod_ff         <= prod_in;
      rem_ff          <= rem_in;
      quo_ff          <= quo_in;
      srem_ff         <= srem_in;
      root_ff         <= root_in;
      best_ff         <= best_in;
      best_edge_ff    <= best_edge_in;
      best_valid_ff   <= best_valid_in;
      tear_found_ff   <= tear_found_in;
      already_torn_ff <= already_torn_in;
      torn_tet_ff     <= torn_tet_in;
      edge_number_ff  <= edge_number_in;
      vertex_a_ff     <= vertex_a_in;
      vertex_b_ff     <= vertex_b_in;
      peak_ff         <= peak_in;
      mid_ff          <= mid_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tear_found    = tear_found_ff;
   assign rsp_already_torn  = already_torn_ff;
   assign rsp_torn_tet      = torn_tet_ff;
   assign rsp_edge_number   = edge_number_ff;
   assign rsp_vertex_a      = vertex_a_ff;
   assign rsp_vertex_b      = vertex_b_ff;
   assign rsp_peak_stretch  = peak_ff;
   assign rsp_tear_midpoint = mid_ff;

endmodule

[test/tb_top.sv]
// Testbench for the tetrahedron tear detector: directed and random requests against a predictor.
`timescale 1ns / 100ps
module tb_top;

   localparam int TETS = 4096;
   localparam int WATCH_LIMIT = 40000;

   typedef struct packed {
      logic        tear_found;
      logic        already_torn;
      logic [11:0] torn_tet;
      logic [2:0]  edge_number;
      logic [11:0] vertex_a;
      logic [11:0] vertex_b;
      logic [15:0] peak_stretch;
      logic [47:0] tear_midpoint;
   } tear_rsp_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_mode = '0;
   logic [11:0] req_tet_number = '0;
   logic [47:0] req_corner_ids = '0;
   logic [15:0] req_resistance = '0;
   logic [47:0] cur_c [4];
   logic [47:0] rest_c [4];
   logic        rsp_valid;
   logic        rsp_stall = 1;
   wire tear_rsp_type rsp_bus;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [15:0] csr_tear_threshold = '0;

   // Predictor state
   logic         torn_map [TETS];
   logic [15:0]  threshold_q;
   tear_rsp_type expected_rsps [$];

   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   hold_off = 0;
   int   errors = 0;
   int   quiet_cycles = 0;

   initial begin
      for (int i = 0; i < 4; i++) begin
         cur_c[i] = '0;
         rest_c[i] = '0;
      end
   end

   always #5 clock = ~clock;

   tetrahedron_tear_detector #(.TETRAHEDRA(TETS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_mode(req_mode), .req_tet_number(req_tet_number),
      .req_corner_ids(req_corner_ids), .req_resistance(req_resistance),
      .req_cur_corner0(cur_c[0]), .req_cur_corner1(cur_c[1]),
      .req_cur_corner2(cur_c[2]), .req_cur_corner3(cur_c[3]),
      .req_rest_corner0(rest_c[0]), .req_rest_corner1(rest_c[1]),
      .req_rest_corner2(rest_c[2]), .req_rest_corner3(rest_c[3]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_tear_found(rsp_bus.tear_found), .rsp_already_torn(rsp_bus.already_torn),
      .rsp_torn_tet(rsp_bus.torn_tet), .rsp_edge_number(rsp_bus.edge_number),
      .rsp_vertex_a(rsp_bus.vertex_a), .rsp_vertex_b(rsp_bus.vertex_b),
      .rsp_peak_stretch(rsp_bus.peak_stretch), .rsp_tear_midpoint(rsp_bus.tear_midpoint),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_tear_threshold(csr_tear_threshold)
   );

   function automatic logic signed [16:0] axis_of(logic [47:0] p, int k);
      return 17'(signed'(p[16*k +: 16]));
   endfunction

   function automatic logic [33:0] edge_len2(logic [47:0] a, logic [47:0] b);
      logic [33:0] sum;
      logic signed [33:0] d;
      sum = '0;
      for (int k = 0; k < 3; k++) begin
         d = axis_of(b, k) - axis_of(a, k);
         sum += 34'(d * d);
      end
      return sum;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic logic [47:0] edge_mid(logic [47:0] a, logic [47:0] b);
      logic [47:0] m;
      logic signed [17:0] s;
      for (int k = 0; k < 3; k++) begin
         s = 18'(axis_of(a, k)) + 18'(axis_of(b, k));
         m[16*k +: 16] = s[16:1];   // arithmetic shift floors toward minus infinity
      end
      return m;
   endfunction

   // Predict the response to one request and update the torn map
   function automatic tear_rsp_type predict_tear(logic [1:0] mode, logic [11:0] tet,
                                                 logic [47:0] ids, logic [15:0] res);
      tear_rsp_type r;
      logic [63:0] best, s, lr;
      int best_e, p, q;
      r = '0;
      r.torn_tet = tet;
      if (mode == ttd_pkg::MODE_CLEAR_ONE) begin
         torn_map[tet] = 0;
         return r;
      end
      if (mode == ttd_pkg::MODE_CLEAR_ALL) begin
         for (int i = 0; i < TETS; i++) torn_map[i] = 0;
         return r;
      end
      if (mode != ttd_pkg::MODE_DETECT) return r;
      if (torn_map[tet]) begin
         r.already_torn = 1;
         return r;
      end
      best = 0;
      best_e = -1;
      for (int e = 0; e < 6; e++) begin
         p = ttd_pkg::edge_p(3'(e));
         q = ttd_pkg::edge_q(3'(e));
         lr = 64'(edge_len2(rest_c[p], rest_c[q]));
         if (lr == 0) s = 4096;
         else s = int_sqrt((64'(edge_len2(cur_c[p], cur_c[q])) << 24) / lr);
         if (s > best) begin
            best = s;
            best_e = e;
         end
      end
      if (best_e >= 0) begin
         p = ttd_pkg::edge_p(3'(best_e));
         q = ttd_pkg::edge_q(3'(best_e));
         r.edge_number = 3'(best_e);
         r.vertex_a = ids[12*p +: 12];
         r.vertex_b = ids[12*q +: 12];
         r.peak_stretch = best > 65535 ? 16'hFFFF : best[15:0];
         r.tear_midpoint = edge_mid(cur_c[p], cur_c[q]);
         if ((best << 12) > 64'(threshold_q) * 64'(res)) begin
            r.tear_found = 1;
            torn_map[tet] = 1;
         end
      end
      return r;
   endfunction

   // Drive the response stall
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Compare each accepted response with the oldest expectation
   always @(posedge clock) begin
      tear_rsp_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_bus);
            errors++;
         end else begin
            exp_r = expected_rsps.pop_front();
            if (exp_r !== rsp_bus) begin
               $display("%0t: mismatch expected %h actual %h", $time, exp_r, rsp_bus);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCH_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Send one request and record its prediction; valid stays up for a following request
   task automatic send_request(logic [1:0] mode, logic [11:0] tet, logic [47:0] ids,
                               logic [15:0] res, logic [47:0] cur[4], logic [47:0] rest[4]);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_mode <= mode;
      req_tet_number <= tet;
      req_corner_ids <= ids;
      req_resistance <= res;
      for (int i = 0; i < 4; i++) begin
         cur_c[i] <= cur[i];
         rest_c[i] <= rest[i];
      end
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsps.insert(expected_rsps.size(), predict_tear(mode, tet, ids, res));
   endtask

   task automatic drain();
      req_valid <= 0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (700) @(posedge clock);
   endtask

   task automatic write_threshold(logic [15:0] v);
      csr_valid <= 1;
      csr_tear_threshold <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      threshold_q = v;
      csr_valid <= 0;
   endtask

   function automatic logic [47:0] rand48();
      return {16'($urandom), $urandom};
   endfunction

   // Small coordinates near a base so stretches stay near one
   function automatic logic [47:0] near(logic [47:0] b, int span);
      logic [47:0] r;
      for (int k = 0; k < 3; k++)
         r[16*k +: 16] = b[16*k +: 16] + 16'($urandom_range(2*span) - span);
      return r;
   endfunction

   task automatic test_directed();
      logic [47:0] c[4], r[4];
      for (int i = 0; i < 4; i++) begin
         r[i] = {16'(i*256), 16'(i*300), 16'(i*200)};
         c[i] = r[i];
      end
      // unit stretch, below default threshold
      send_request(ttd_pkg::MODE_DETECT, 12'd0, 48'hFFF_ABC_123_000, 16'd4096, c, r);
      // stretched edge tears
      c[3] = {16'h0C00, 16'h0E00, 16'h0A00};
      send_request(ttd_pkg::MODE_DETECT, 12'd1, 48'h003_002_001_000, 16'd4096, c, r);
      send_request(ttd_pkg::MODE_DETECT, 12'd1, 48'h003_002_001_000, 16'd4096, c, r);
      send_request(ttd_pkg::MODE_CLEAR_ONE, 12'd1, '0, '0, c, r);
      send_request(ttd_pkg::MODE_DETECT, 12'd1, 48'hFFF_FFF_FFF_FFF, 16'd0, c, r);
      // degenerate rest edges and all-zero input
      for (int i = 0; i < 4; i++) begin
         r[i] = '0;
         c[i] = '0;
      end
      send_request(ttd_pkg::MODE_DETECT, 12'd2, '0, 16'd0, c, r);
      for (int i = 0; i < 4; i++) r[i] = {16'(i), 16'(i), 16'(i)};
      send_request(ttd_pkg::MODE_DETECT, 12'd3, rand48(), 16'hFFFF, c, r);
      // extremes of coordinates: saturated stretch
      c[0] = 48'h8000_8000_8000;
      c[1] = 48'h7FFF_7FFF_7FFF;
      c[2] = 48'h8000_7FFF_8000;
      c[3] = 48'h7FFF_8000_7FFF;
      send_request(ttd_pkg::MODE_DETECT, 12'hFFF, 48'hFFF_000_FFF_000, 16'd1, c, r);
      send_request(ttd_pkg::MODE_DETECT, 12'hFFE, rand48(), 16'hFFFF, c, r);
      send_request(ttd_pkg::MODE_CLEAR_ALL, 12'd0, '0, '0, c, r);
      send_request(ttd_pkg::MODE_DETECT, 12'hFFF, rand48(), 16'hFFFF, c, r);
      send_request(ttd_pkg::MODE_IGNORED, 12'd5, rand48(), 16'hFFFF, c, r);
      send_request(ttd_pkg::MODE_DETECT, 12'd5, rand48(), 16'h0000, c, r);
      drain();
   endtask

   task automatic run_random(int count);
      logic [47:0] c[4], r[4], base;
      int kind;
      logic [11:0] tet;
      logic [1:0] mode;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(99);
         tet = (kind < 70) ? 12'($urandom_range(31)) : 12'($urandom);
         mode = ttd_pkg::MODE_DETECT;
         if (kind >= 90) mode = 2'($urandom);
         else if (kind >= 84) mode = ttd_pkg::MODE_CLEAR_ONE;
         if ($urandom_range(99) == 0) mode = ttd_pkg::MODE_CLEAR_ALL;
         base = rand48();
         for (int i = 0; i < 4; i++) begin
            if (kind < 75) begin
               r[i] = near(base, 1200);
               c[i] = near(r[i], 400);
            end else begin
               r[i] = ($urandom_range(9) == 0) ? base : rand48();
               c[i] = rand48();
            end
         end
         send_request(mode, tet, rand48(), 16'($urandom_range(8192)) | 16'($urandom & 16'hC000 &
                      {16{kind[0] & kind[1]}}), c, r);
      end
   endtask

   task automatic test_backpressure();
      hold_off = 2000;
      run_random(12);
      drain();
   endtask

   initial begin
      threshold_q = ttd_pkg::THR_RESET;
      for (int i = 0; i < TETS; i++) torn_map[i] = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      test_directed();
      write_threshold(16'd0);
      send_idle_pct = 8;
      recv_idle_pct = 86;
      run_random(150);
      drain();
      write_threshold(16'hFFFF);
      send_idle_pct = 86;
      recv_idle_pct = 8;
      run_random(150);
      drain();
      write_threshold(16'd4500);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(150);
      drain();
      test_backpressure();
      if (errors == 0 && expected_rsps.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
